// ----- sv/dts_pkg.sv -----
// Package for the 2D strided DMA tile engine.
// Holds queue sizing, command codes and the cycle/result payload structs.
// No dependencies.
package dts_pkg;

	localparam int QUEUE_DEPTH = 16;
	localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);
	localparam int BEAT_BYTES  = 8;

	localparam logic [1:0] CMD_NONE      = 2'd0;
	localparam logic [1:0] CMD_TO_ACCEL  = 2'd1;
	localparam logic [1:0] CMD_TO_MEM    = 2'd2;

	localparam logic [4:0] LEN_INVALID   = 5'd31;

	// One bus cycle of inputs.
	typedef struct packed {
		logic [1:0]  cmd;
		logic [31:0] req_cpu_addr;
		logic [31:0] req_accel_addr;
		logic [4:0]  length_code;
		logic [7:0]  tile_row;
		logic [7:0]  row_mult;
		logic        write_ready;
		logic        read_addr_ready;
		logic        read_data_ready;
	} cyc_item_t;

	// One bus cycle of outputs.
	typedef struct packed {
		logic        can_queue;
		logic        engine_idle;
		logic        write_enable;
		logic        read_addr_enable;
		logic        read_data_enable;
		logic [31:0] beat_accel_addr;
		logic [31:0] beat_cpu_addr;
		logic        beat_done;
		logic        transfer_done;
		logic        length_error;
	} res_item_t;

	// Queued / active request.
	typedef struct packed {
		logic        to_accel;
		logic [31:0] cpu;
		logic [31:0] accel;
		logic [4:0]  len;
		logic [7:0]  sx;
		logic [7:0]  sy;
	} dma_req_t;

endpackage

// ----- sv/dma_tile_stride_engine.sv -----
// 2D strided DMA tile engine: request queue, beat sequencer and address stepper.
// Uses dts_pkg for sizing, command codes and payload structs.
//
// Usage:
//   cyc channel: one item per modeled bus cycle (request command and fields
//   plus the accelerator ready strobes). Item accepted when cyc_valid is high
//   and cyc_stall is low.
//   res channel: one result per accepted item, in order, accepted when
//   res_valid is high and res_stall is low.
//   The whole cycle (queue pop, beat drive, address step, queue push) is
//   evaluated in the accepting clock; the result is registered into the
//   output register, or into the skid register while the output is stalled.
//   Throughput is one item per cycle while cyc_stall is low.
//   A two-entry output (result register plus skid register) lets an item be
//   taken while the previous result is stalled; cyc_stall rises only when
//   both entries hold results.
//   Reset (arst_n low) empties the queue, sets the engine idle and clears the
//   pointers; queue entries themselves are not cleared.
module dma_tile_stride_engine (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cyc_valid,
	output logic               cyc_stall,
	input  dts_pkg::cyc_item_t cyc,
	output logic               res_valid,
	input  logic               res_stall,
	output dts_pkg::res_item_t res
);
	import dts_pkg::*;

	localparam logic [1:0] PH_IDLE  = 2'd0;
	localparam logic [1:0] PH_WRITE = 2'd1;
	localparam logic [1:0] PH_RADDR = 2'd2;
	localparam logic [1:0] PH_RDATA = 2'd3;

	localparam logic [QUEUE_AW:0]   DEPTH_C = (QUEUE_AW+1)'(QUEUE_DEPTH);
	localparam logic [QUEUE_AW-1:0] LAST_C  = QUEUE_AW'(QUEUE_DEPTH - 1);
	localparam logic [30:0]         BEAT_C  = 31'(BEAT_BYTES);

	dma_req_t              queue_q [QUEUE_DEPTH];
	dma_req_t              head_ent_q;
	logic [QUEUE_AW-1:0]   head_q;
	logic [QUEUE_AW:0]     count_q;
	logic [1:0]            phase_q;
	dma_req_t              active_q;
	logic [30:0]           offset_q;
	logic [31:0]           ptr_q;
	logic [7:0]            tpos_q;

	res_item_t             out_q, skid_q;
	logic                  out_valid_q, skid_valid_q;

	logic                  acc, take;
	logic                  can_q, idle_now, pop, push, beat, last_beat;
	dma_req_t              req, head_ent, new_ent;
	logic [1:0]            ph, phase_n;
	logic [30:0]           off, off_n, bytes;
	logic [31:0]           ptr, ptr_n;
	logic [7:0]            tpos, tpos_n;
	logic [8:0]            tpos_sum;
	logic [15:0]           row_step;
	logic [QUEUE_AW-1:0]   head_n, tail;
	logic [QUEUE_AW+1:0]   tail_sum;
	logic [QUEUE_AW:0]     count_n;
	res_item_t             r;

	assign cyc_stall = skid_valid_q;
	assign acc       = cyc_valid && !skid_valid_q;
	assign take      = out_valid_q && !res_stall;
	assign res_valid = out_valid_q;
	assign res       = out_q;

	// head slot is registered ahead of use, from the next head index
	assign head_ent = head_ent_q;

	always_comb begin
		can_q    = count_q < DEPTH_C;
		idle_now = (phase_q == PH_IDLE) && (count_q == '0);
		pop      = (phase_q == PH_IDLE) && (count_q != '0);

		// state as seen after a pop in this cycle
		req  = pop ? head_ent : active_q;
		ph   = pop ? (head_ent.to_accel ? PH_WRITE : PH_RADDR) : phase_q;
		off  = pop ? '0 : offset_q;
		ptr  = pop ? head_ent.accel : ptr_q;
		tpos = pop ? '0 : tpos_q;
		head_n = pop ? ((head_q == LAST_C) ? '0 : head_q + QUEUE_AW'(1)) : head_q;

		r = '0;
		r.can_queue        = can_q;
		r.engine_idle      = idle_now;
		r.write_enable     = ph == PH_WRITE;
		r.read_addr_enable = ph == PH_RADDR;
		r.read_data_enable = ph == PH_RDATA;
		if (ph != PH_IDLE) begin
			r.beat_accel_addr = ptr;
			r.beat_cpu_addr   = req.cpu + {1'b0, off};
		end

		// push: tail slot is the same before or after the pop
		push = 1'b0;
		if ((cyc.cmd == CMD_TO_ACCEL || cyc.cmd == CMD_TO_MEM) && can_q) begin
			if (cyc.length_code >= LEN_INVALID) begin
				r.length_error = 1'b1;
			end else begin
				push = 1'b1;
			end
		end
		tail_sum = {2'b0, head_q} + {1'b0, count_q};
		if (tail_sum >= {1'b0, DEPTH_C}) begin
			tail_sum = tail_sum - {1'b0, DEPTH_C};
		end
		tail = tail_sum[QUEUE_AW-1:0];
		new_ent.to_accel = cyc.cmd == CMD_TO_ACCEL;
		new_ent.cpu      = cyc.req_cpu_addr;
		new_ent.accel    = cyc.req_accel_addr;
		new_ent.len      = cyc.length_code;
		new_ent.sx       = cyc.tile_row;
		new_ent.sy       = cyc.row_mult;
		count_n = count_q - {{QUEUE_AW{1'b0}}, pop} + {{QUEUE_AW{1'b0}}, push};

		// beat completion and tile stepping
		beat = (ph == PH_WRITE && cyc.write_ready) || (ph == PH_RDATA && cyc.read_data_ready);
		off_n    = off + BEAT_C;
		tpos_sum = {1'b0, tpos} + 9'(BEAT_BYTES);
		row_step = req.sx * req.sy;
		if (req.sx != '0 && tpos_sum >= {1'b0, req.sx}) begin
			ptr_n  = ptr + {16'd0, row_step} - {24'd0, tpos};
			tpos_n = '0;
		end else begin
			ptr_n  = ptr + 32'(BEAT_BYTES);
			tpos_n = tpos_sum[7:0];
		end
		bytes     = 31'd1 << req.len;
		last_beat = off_n >= bytes;

		phase_n = ph;
		if (beat) begin
			r.beat_done = 1'b1;
			if (last_beat) begin
				r.transfer_done = 1'b1;
				phase_n = PH_IDLE;
			end else begin
				phase_n = (ph == PH_WRITE) ? PH_WRITE : PH_RADDR;
			end
		end else if (ph == PH_RADDR && cyc.read_addr_ready) begin
			phase_n = PH_RDATA;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q   <= '0;
			count_q  <= '0;
			phase_q  <= PH_IDLE;
			active_q <= '0;
			offset_q <= '0;
			ptr_q    <= '0;
			tpos_q   <= '0;
		end else if (acc) begin
			head_q   <= head_n;
			count_q  <= count_n;
			phase_q  <= phase_n;
			active_q <= req;
			offset_q <= beat ? off_n : off;
			ptr_q    <= beat ? ptr_n : ptr;
			tpos_q   <= beat ? tpos_n : tpos;
		end
	end

	// a push into an empty queue goes straight to the head register
	always_ff @(posedge clk) begin
		if (acc && push) begin
			queue_q[tail] <= new_ent;
		end
		if (acc) begin
			head_ent_q <= (push && tail == head_n) ? new_ent : queue_q[head_n];
		end
	end

	// result register with one skid entry
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (skid_valid_q) begin
			if (take) begin
				skid_valid_q <= 1'b0;
			end
		end else if (acc) begin
			if (out_valid_q && !take) begin
				skid_valid_q <= 1'b1;
			end else begin
				out_valid_q <= 1'b1;
			end
		end else if (take) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (skid_valid_q) begin
			if (take) begin
				out_q <= skid_q;
			end
		end else if (acc) begin
			if (out_valid_q && !take) begin
				skid_q <= r;
			end else begin
				out_q <= r;
			end
		end
	end

	a_skid_implies_out: assert property (@(posedge clk) disable iff (!arst_n)
		skid_valid_q |-> out_valid_q)
		else $error("skid entry held without a result in the output register");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= DEPTH_C)
		else $error("queue count above depth");

	a_done_has_beat: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_q.transfer_done) |-> out_q.beat_done)
		else $error("transfer done without a beat");

	a_one_enable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> $onehot0({out_q.write_enable, out_q.read_addr_enable,
			out_q.read_data_enable}))
		else $error("more than one beat enable in a result");

	a_skid_drain: assert property (@(posedge clk) disable iff (!arst_n)
		(skid_valid_q && !res_stall) |=> (out_valid_q && !skid_valid_q))
		else $error("skid entry not moved to output after transfer");

endmodule
